[rtl/mht_pkg.sv]
package mht_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int KEY_W  = 16;
    localparam int HID_W  = 16;
    localparam int FLAG_W = 32;
    localparam int REQ_W  = 2;
    localparam int STS_W  = 3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP     = 2'd2;

    // Status codes.
    localparam logic [STS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STS_W-1:0] ST_NEG_KEY      = 3'd1;
    localparam logic [STS_W-1:0] ST_NULL_HANDLER = 3'd2;
    localparam logic [STS_W-1:0] ST_DUPLICATE    = 3'd3;
    localparam logic [STS_W-1:0] ST_FULL         = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [HID_W-1:0]  handler;
        logic [FLAG_W-1:0] flag_one;
        logic [FLAG_W-1:0] flag_two;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

[rtl/mht_ctrl.sv]
module mht_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mht_pkg::sts_t sts,
    output mht_pkg::cmd_t cmd
);

    mht_pkg::state_t state_reg;
    mht_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mht_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            mht_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mht_pkg::S_SCAN;
                end
            end
            mht_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = mht_pkg::S_DRAIN;
                end
            end
            // The last entry read is compared in this cycle.
            mht_pkg::S_DRAIN:
            begin
                state_next = mht_pkg::S_FINISH;
            end
            mht_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = mht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/mht_datapath.sv]
module mht_datapath
#(
    parameter int TABLE_DEPTH = mht_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mht_pkg::cmd_t                     cmd,
    output mht_pkg::sts_t                     sts,
    input  logic [mht_pkg::REQ_W-1:0]         req_type,
    input  logic signed [mht_pkg::KEY_W-1:0]  msg_key,
    input  logic [mht_pkg::HID_W-1:0]         handler_id,
    input  logic signed [mht_pkg::FLAG_W-1:0] flag_one,
    input  logic signed [mht_pkg::FLAG_W-1:0] flag_two,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mht_pkg::STS_W-1:0]         status,
    output logic                              hit,
    output logic [mht_pkg::HID_W-1:0]         handler_out,
    output logic signed [mht_pkg::FLAG_W-1:0] flag_one_out,
    output logic signed [mht_pkg::FLAG_W-1:0] flag_two_out
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Entry storage; data is only ever read behind a set used bit.
    mht_pkg::entry_t mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used_reg;

    // Captured request.
    logic [mht_pkg::REQ_W-1:0]  req_reg;
    logic [mht_pkg::KEY_W-1:0]  key_reg;
    logic [mht_pkg::HID_W-1:0]  hid_reg;
    logic [mht_pkg::FLAG_W-1:0] f1_reg;
    logic [mht_pkg::FLAG_W-1:0] f2_reg;

    // Scan pipeline.
    logic [IW-1:0]   cnt_reg;
    logic            rd_vld_reg;
    logic [IW-1:0]   rd_idx_reg;
    logic            rd_used_reg;
    mht_pkg::entry_t rd_entry_reg;

    // Scan results.
    logic          found_reg;
    logic [IW-1:0] found_idx_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [mht_pkg::HID_W-1:0]  match_hid_reg;
    logic [mht_pkg::FLAG_W-1:0] match_f1_reg;
    logic [mht_pkg::FLAG_W-1:0] match_f2_reg;

    // Output register.
    logic                       out_valid_reg;
    logic [mht_pkg::STS_W-1:0]  status_reg;
    logic                       hit_reg;
    logic [mht_pkg::HID_W-1:0]  handler_reg;
    logic [mht_pkg::FLAG_W-1:0] f1_out_reg;
    logic [mht_pkg::FLAG_W-1:0] f2_out_reg;

    // Result of the request, settled once the scan has drained.
    logic [mht_pkg::STS_W-1:0] res_status;
    logic                      do_write;
    logic                      do_free;
    logic                      res_hit;

    assign sts.scan_last = (cnt_reg == IW'(TABLE_DEPTH - 1));
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            key_reg <= $unsigned(msg_key);
            hid_reg <= handler_id;
            f1_reg  <= $unsigned(flag_one);
            f2_reg  <= $unsigned(flag_two);
        end
        rd_entry_reg <= mem[cnt_reg];
        rd_idx_reg   <= cnt_reg;
        rd_used_reg  <= used_reg[cnt_reg];
        if (cmd.commit && do_write)
        begin
            mem[free_idx_reg] <= '{key_reg, hid_reg, f1_reg, f2_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            found_idx_reg  <= '0;
            free_idx_reg   <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                cnt_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                // Keep only the lowest matching entry and the lowest free one.
                if (rd_vld_reg && rd_used_reg && !found_reg
                    && rd_entry_reg.key == key_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= rd_idx_reg;
                end
                if (rd_vld_reg && !rd_used_reg && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
            end
            if (cmd.commit && do_write)
            begin
                used_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.commit && do_free)
            begin
                used_reg[found_idx_reg] <= 1'b0;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && rd_used_reg && !found_reg && rd_entry_reg.key == key_reg)
        begin
            match_hid_reg <= rd_entry_reg.handler;
            match_f1_reg  <= rd_entry_reg.flag_one;
            match_f2_reg  <= rd_entry_reg.flag_two;
        end
    end

    always_comb
    begin
        res_status = mht_pkg::ST_OK;
        do_write   = 1'b0;
        do_free    = 1'b0;
        res_hit    = 1'b0;
        case (req_reg)
            mht_pkg::REQ_REGISTER:
            begin
                if (key_reg[mht_pkg::KEY_W-1])
                begin
                    res_status = mht_pkg::ST_NEG_KEY;
                end
                else if (hid_reg == '0)
                begin
                    res_status = mht_pkg::ST_NULL_HANDLER;
                end
                else if (found_reg)
                begin
                    res_status = mht_pkg::ST_DUPLICATE;
                end
                else if (!free_found_reg)
                begin
                    res_status = mht_pkg::ST_FULL;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            mht_pkg::REQ_UNREGISTER:
            begin
                do_free = found_reg;
            end
            mht_pkg::REQ_LOOKUP:
            begin
                res_hit = found_reg;
            end
            default:
            begin
                res_status = mht_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= res_status;
            hit_reg     <= res_hit;
            handler_reg <= res_hit ? match_hid_reg : '0;
            f1_out_reg  <= res_hit ? match_f1_reg : '0;
            f2_out_reg  <= res_hit ? match_f2_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign handler_out  = handler_reg;
    assign flag_one_out = $signed(f1_out_reg);
    assign flag_two_out = $signed(f2_out_reg);

endmodule

[rtl/message_handler_table_top.sv]
// Message handler table: maps a 16-bit message key to a handler id and two
// 32-bit flag words, with register, unregister and lookup requests.
// The request channel (in_valid/in_ready) carries req_type, msg_key,
// handler_id, flag_one and flag_two; each transaction yields exactly one
// result transaction on out_valid/out_ready with status, hit, handler_out,
// flag_one_out and flag_two_out.
// A request is handled by reading the entry memory once per entry, one
// entry per cycle, then comparing the last entry read and loading the
// result register.
// The block takes one request at a time: in_ready is high only while idle,
// so a new request is accepted only once the previous one has loaded its
// result.
// Results sit in an output register. When the receiver stalls, the result
// holds steady and the next request runs its scan anyway; it waits only to
// load its result until the previous one has been taken.
// Reset clears all used bits and the output valid; the table is empty and
// ready right after reset, with no clearing pass.
module message_handler_table_top
#(
    parameter int TABLE_DEPTH = mht_pkg::TABLE_DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mht_pkg::REQ_W-1:0]         req_type,
    input  logic signed [mht_pkg::KEY_W-1:0]  msg_key,
    input  logic [mht_pkg::HID_W-1:0]         handler_id,
    input  logic signed [mht_pkg::FLAG_W-1:0] flag_one,
    input  logic signed [mht_pkg::FLAG_W-1:0] flag_two,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mht_pkg::STS_W-1:0]         status,
    output logic                              hit,
    output logic [mht_pkg::HID_W-1:0]         handler_out,
    output logic signed [mht_pkg::FLAG_W-1:0] flag_one_out,
    output logic signed [mht_pkg::FLAG_W-1:0] flag_two_out
);

    mht_pkg::cmd_t cmd;
    mht_pkg::sts_t sts;

    mht_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mht_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req_type),
        .msg_key      (msg_key),
        .handler_id   (handler_id),
        .flag_one     (flag_one),
        .flag_two     (flag_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .hit          (hit),
        .handler_out  (handler_out),
        .flag_one_out (flag_one_out),
        .flag_two_out (flag_two_out)
    );

endmodule

[rtl/mht_checker.sv]
module mht_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [mht_pkg::STS_W-1:0]         status,
    input logic                              hit,
    input logic [mht_pkg::HID_W-1:0]         handler_out,
    input logic signed [mht_pkg::FLAG_W-1:0] flag_one_out,
    input logic signed [mht_pkg::FLAG_W-1:0] flag_two_out
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(hit)
            && $stable(handler_out) && $stable(flag_one_out) && $stable(flag_two_out))
        else $error("result changed while stalled");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // A miss returns zero data.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> handler_out == '0 && flag_one_out == '0
            && flag_two_out == '0)
        else $error("nonzero data without a hit");

    // A hit only comes from a successful lookup of a stored, non-null handler.
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> status == mht_pkg::ST_OK && handler_out != '0)
        else $error("hit with failure status or null handler");

endmodule

bind message_handler_table_top mht_checker u_mht_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .hit          (hit),
    .handler_out  (handler_out),
    .flag_one_out (flag_one_out),
    .flag_two_out (flag_two_out)
);

[sim/message_handler_table_top_tb.sv]
`timescale 1ns / 100ps

module message_handler_table_top_tb;

    localparam int DEPTH       = mht_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 205;

    // The one request code that the package leaves unnamed.
    localparam logic [mht_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [mht_pkg::REQ_W-1:0]  req;
        logic [mht_pkg::KEY_W-1:0]  key;
        logic [mht_pkg::HID_W-1:0]  hid;
        logic [mht_pkg::FLAG_W-1:0] f1;
        logic [mht_pkg::FLAG_W-1:0] f2;
    } request_t;

    typedef struct packed {
        logic [mht_pkg::STS_W-1:0]  status;
        logic                       hit;
        logic [mht_pkg::HID_W-1:0]  handler;
        logic [mht_pkg::FLAG_W-1:0] f1;
        logic [mht_pkg::FLAG_W-1:0] f2;
    } result_t;

    typedef struct packed {
        request_t rq;
        logic [4:0] reps;
        logic       typed;
        result_t    res;
    } dir_row_t;

    localparam result_t ZERO_RES = '{mht_pkg::ST_OK, 1'b0, 16'h0, 32'h0, 32'h0};
    localparam result_t NEG_RES  = '{mht_pkg::ST_NEG_KEY, 1'b0, 16'h0, 32'h0, 32'h0};
    localparam result_t NULL_RES = '{mht_pkg::ST_NULL_HANDLER, 1'b0, 16'h0, 32'h0, 32'h0};
    localparam result_t DUP_RES  = '{mht_pkg::ST_DUPLICATE, 1'b0, 16'h0, 32'h0, 32'h0};
    localparam result_t FULL_RES = '{mht_pkg::ST_FULL, 1'b0, 16'h0, 32'h0, 32'h0};

    localparam int NUM_ROWS = 21;

    // A row with reps above one registers consecutive keys and handlers.
    dir_row_t dir_rows [NUM_ROWS] = '{
        '{'{mht_pkg::REQ_LOOKUP, 16'h0000, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_UNREGISTER, 16'h0005, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h8000, 16'h0001, 32'h1, 32'h1},
          5'd1, 1'b1, NEG_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'hFFFF, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, NEG_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h0007, 16'h0000, 32'h5, 32'h6},
          5'd1, 1'b1, NULL_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h0000, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_LOOKUP, 16'h0000, 16'h0000, 32'h0, 32'h0}, 5'd1, 1'b1,
          '{mht_pkg::ST_OK, 1'b1, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF}},
        '{'{mht_pkg::REQ_REGISTER, 16'h7FFF, 16'h0001, 32'hFFFFFFFF, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_LOOKUP, 16'h7FFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
          5'd1, 1'b1, '{mht_pkg::ST_OK, 1'b1, 16'h0001, 32'hFFFFFFFF, 32'h0}},
        '{'{mht_pkg::REQ_REGISTER, 16'h0000, 16'h0005, 32'h0, 32'h0},
          5'd1, 1'b1, DUP_RES},
        '{'{mht_pkg::REQ_LOOKUP, 16'hFFFF, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_UNREGISTER, 16'h8000, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{REQ_UNUSED, 16'h1234, 16'hBEEF, 32'hDEADBEEF, 32'hCAFEF00D},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_UNREGISTER, 16'h0000, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_LOOKUP, 16'h0000, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h0001, 16'h0100, 32'hA5A50000, 32'h5A5A0000},
          5'd15, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h0014, 16'h0033, 32'h0, 32'h0},
          5'd1, 1'b1, FULL_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h7FFF, 16'h0033, 32'h0, 32'h0},
          5'd1, 1'b1, DUP_RES},
        '{'{mht_pkg::REQ_UNREGISTER, 16'h0009, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_REGISTER, 16'h0015, 16'h4242, 32'h01234567, 32'h89ABCDEF},
          5'd1, 1'b1, ZERO_RES},
        '{'{mht_pkg::REQ_LOOKUP, 16'h0015, 16'h0000, 32'h0, 32'h0},
          5'd1, 1'b0, ZERO_RES}
    };

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              in_valid     = 1'b0;
    logic                              in_ready;
    logic [mht_pkg::REQ_W-1:0]         req_type     = '0;
    logic signed [mht_pkg::KEY_W-1:0]  msg_key      = '0;
    logic [mht_pkg::HID_W-1:0]         handler_id   = '0;
    logic signed [mht_pkg::FLAG_W-1:0] flag_one     = '0;
    logic signed [mht_pkg::FLAG_W-1:0] flag_two     = '0;
    logic                              out_valid;
    logic                              out_ready    = 1'b0;
    logic [mht_pkg::STS_W-1:0]         status;
    logic                              hit;
    logic [mht_pkg::HID_W-1:0]         handler_out;
    logic signed [mht_pkg::FLAG_W-1:0] flag_one_out;
    logic signed [mht_pkg::FLAG_W-1:0] flag_two_out;

    // Shadow copy of the table.
    bit                       ent_used [DEPTH];
    bit [mht_pkg::KEY_W-1:0]  ent_key  [DEPTH];
    bit [mht_pkg::HID_W-1:0]  ent_hid  [DEPTH];
    bit [mht_pkg::FLAG_W-1:0] ent_f1   [DEPTH];
    bit [mht_pkg::FLAG_W-1:0] ent_f2   [DEPTH];

    result_t pending_results [$];
    result_t want_res;
    int      mismatch_count = 0;
    int      send_idle_pct  = 31;
    int      recv_idle_pct  = 59;
    int      cycle_count    = 0;

    message_handler_table_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .msg_key      (msg_key),
        .handler_id   (handler_id),
        .flag_one     (flag_one),
        .flag_two     (flag_two),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .hit          (hit),
        .handler_out  (handler_out),
        .flag_one_out (flag_one_out),
        .flag_two_out (flag_two_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int find_entry(input logic [mht_pkg::KEY_W-1:0] key);
        int idx;
        idx = DEPTH;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (ent_used[i] && ent_key[i] == key)
                idx = i;
        end
        return idx;
    endfunction

    function automatic result_t table_apply(input request_t rq);
        result_t res;
        int      idx;
        int      slot;
        res  = ZERO_RES;
        idx  = find_entry(rq.key);
        slot = DEPTH;
        case (rq.req)
            mht_pkg::REQ_REGISTER:
            begin
                for (int i = DEPTH - 1; i >= 0; i--)
                begin
                    if (!ent_used[i])
                        slot = i;
                end
                if (rq.key[mht_pkg::KEY_W-1])
                    res.status = mht_pkg::ST_NEG_KEY;
                else if (rq.hid == '0)
                    res.status = mht_pkg::ST_NULL_HANDLER;
                else if (idx < DEPTH)
                    res.status = mht_pkg::ST_DUPLICATE;
                else if (slot == DEPTH)
                    res.status = mht_pkg::ST_FULL;
                else
                begin
                    ent_used[slot] = 1'b1;
                    ent_key[slot]  = rq.key;
                    ent_hid[slot]  = rq.hid;
                    ent_f1[slot]   = rq.f1;
                    ent_f2[slot]   = rq.f2;
                end
            end
            mht_pkg::REQ_UNREGISTER:
            begin
                if (idx < DEPTH)
                begin
                    ent_used[idx] = 1'b0;
                    ent_key[idx]  = '0;
                    ent_hid[idx]  = '0;
                    ent_f1[idx]   = '0;
                    ent_f2[idx]   = '0;
                end
            end
            mht_pkg::REQ_LOOKUP:
            begin
                if (idx < DEPTH)
                begin
                    res.hit     = 1'b1;
                    res.handler = ent_hid[idx];
                    res.f1      = ent_f1[idx];
                    res.f2      = ent_f2[idx];
                end
            end
            default:
                res = ZERO_RES;
        endcase
        return res;
    endfunction

    // Mostly keys from a small pool or already in the table, so that
    // duplicates, hits and a full table come up often.
    function automatic logic [mht_pkg::KEY_W-1:0] pick_key();
        logic [mht_pkg::KEY_W-1:0] stored [$];
        int sel;
        sel = $urandom_range(99);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ent_used[i])
                stored.push_back(ent_key[i]);
        end
        if (sel < 20)
            return 16'($urandom());
        else if (sel < 55 && stored.size() != 0)
            return stored[$urandom_range(stored.size() - 1)];
        else
            return 16'($urandom_range(23));
    endfunction

    function automatic request_t random_req(input bit filling);
        request_t rq;
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            rq.req = REQ_UNUSED;
        else if (sel < (filling ? 60 : 30))
            rq.req = mht_pkg::REQ_REGISTER;
        else if (sel < (filling ? 72 : 65))
            rq.req = mht_pkg::REQ_UNREGISTER;
        else
            rq.req = mht_pkg::REQ_LOOKUP;
        rq.key = pick_key();
        sel = $urandom_range(99);
        if (sel < 6)
            rq.hid = '0;
        else if (sel < 12)
            rq.hid = '1;
        else
            rq.hid = 16'($urandom_range(1, 65535));
        rq.f1 = $urandom();
        rq.f2 = $urandom();
        return rq;
    endfunction

    task automatic send_req(input request_t rq, input bit typed, input result_t typed_res);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq.req;
        msg_key    <= rq.key;
        handler_id <= rq.hid;
        flag_one   <= rq.f1;
        flag_two   <= rq.f2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = table_apply(rq);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result transaction with no request outstanding, status %h",
                         $time, status);
                mismatch_count++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                check_field("status", 32'(want_res.status), 32'(status));
                check_field("hit", 32'(want_res.hit), 32'(hit));
                check_field("handler_out", 32'(want_res.handler), 32'(handler_out));
                check_field("flag_one_out", want_res.f1, flag_one_out);
                check_field("flag_two_out", want_res.f2, flag_two_out);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("message_handler_table_top_tb: FAIL");
        $finish;
    end

    initial
    begin
        request_t rq;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            for (int r = 0; r < dir_rows[i].reps; r++)
            begin
                rq      = dir_rows[i].rq;
                rq.key  = rq.key + 16'(r);
                rq.hid  = rq.hid + 16'(r);
                rq.f1   = rq.f1 + 32'(r);
                rq.f2   = rq.f2 + 32'(r);
                send_req(rq, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 31 : 0;
            // Alternate stretches that push the table toward full and toward empty.
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_req(random_req(((n / 40) % 2) == 0), 1'b0, ZERO_RES);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * (DEPTH + 3)) @(posedge clk);

        if (mismatch_count == 0)
            $display("message_handler_table_top_tb: PASS");
        else
            $display("message_handler_table_top_tb: FAIL");
        $finish;
    end

endmodule

[message_handler_table_top.f]
rtl/mht_pkg.sv
rtl/mht_ctrl.sv
rtl/mht_datapath.sv
rtl/message_handler_table_top.sv
rtl/mht_checker.sv
sim/message_handler_table_top_tb.sv
